>>> hdl/gqc_pkg.sv
// ----------------------------------------------------------------------------
// gqc_pkg
// Shared constants, codes and types of the genotype QC statistics accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package gqc_pkg;

  localparam int NUM_SAMPLES     = 1024;
  localparam int PLOIDY          = 2;
  localparam int MAX_ALLELES     = 64;
  localparam int MULTI_THRESHOLD = 2;
  localparam int NCOL            = 23;

  localparam int SAMPLE_W = 10;
  localparam int VAL_W    = 31;
  localparam int ALLELE_W = 7;
  localparam int CLASS_W  = 3;
  localparam int SLOT_W   = 2;
  localparam int COL_W    = 5;
  localparam int CNT_W    = 64;
  localparam int INC_W    = 2;

  localparam int RAM_DEPTH = NUM_SAMPLES * NCOL;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam logic OPC_ACC  = 1'b0;
  localparam logic OPC_READ = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_OTHER = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_TI    = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_TV    = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_INS   = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_DEL   = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_STAR  = 3'd5;

  localparam logic [COL_W-1:0] C_DP_SUM     = 5'd0;
  localparam logic [COL_W-1:0] C_DP_SUM2    = 5'd1;
  localparam logic [COL_W-1:0] C_DP_COUNT   = 5'd2;
  localparam logic [COL_W-1:0] C_DP_MIN     = 5'd3;
  localparam logic [COL_W-1:0] C_DP_MAX     = 5'd4;
  localparam logic [COL_W-1:0] C_GQ_SUM     = 5'd5;
  localparam logic [COL_W-1:0] C_GQ_SUM2    = 5'd6;
  localparam logic [COL_W-1:0] C_GQ_COUNT   = 5'd7;
  localparam logic [COL_W-1:0] C_GQ_MIN     = 5'd8;
  localparam logic [COL_W-1:0] C_GQ_MAX     = 5'd9;
  localparam logic [COL_W-1:0] C_RECORDS    = 5'd10;
  localparam logic [COL_W-1:0] C_CALLED     = 5'd11;
  localparam logic [COL_W-1:0] C_NOT_CALLED = 5'd12;
  localparam logic [COL_W-1:0] C_HOM_REF    = 5'd13;
  localparam logic [COL_W-1:0] C_HET        = 5'd14;
  localparam logic [COL_W-1:0] C_SINGLETON  = 5'd15;
  localparam logic [COL_W-1:0] C_SNP        = 5'd16;
  localparam logic [COL_W-1:0] C_INS        = 5'd17;
  localparam logic [COL_W-1:0] C_DEL        = 5'd18;
  localparam logic [COL_W-1:0] C_TI         = 5'd19;
  localparam logic [COL_W-1:0] C_TV         = 5'd20;
  localparam logic [COL_W-1:0] C_STAR       = 5'd21;
  localparam logic [COL_W-1:0] C_MULTI      = 5'd22;
  localparam logic [COL_W-1:0] C_END        = 5'd23;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ_DP,
    ST_SQ_GQ,
    ST_ACC,
    ST_RD_DP,
    ST_RD_GQ,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_RD_WAIT
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MIN,
    ALU_MAX
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    en;
  } alu_ctl_t;

  typedef struct packed {
    logic [INC_W-1:0] called;
    logic [INC_W-1:0] not_called;
    logic [INC_W-1:0] hom_ref;
    logic [INC_W-1:0] het;
    logic [INC_W-1:0] singleton;
    logic [INC_W-1:0] snp;
    logic [INC_W-1:0] ins;
    logic [INC_W-1:0] del;
    logic [INC_W-1:0] ti;
    logic [INC_W-1:0] tv;
    logic [INC_W-1:0] star;
    logic [INC_W-1:0] multi;
  } geno_t;

  // The minimum counters start from all ones, every other counter from zero.
  function automatic logic [CNT_W-1:0] col_init(input logic [COL_W-1:0] col);
    return (col == C_DP_MIN || col == C_GQ_MIN) ? '1 : '0;
  endfunction

endpackage

`default_nettype wire

>>> hdl/gqc_if.sv
// ----------------------------------------------------------------------------
// gqc_if
// Valid/ready channels for record items and counter items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gqc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic [gqc_pkg::SAMPLE_W-1:0]         sample_index;
  logic                                 depth_present;
  logic [gqc_pkg::VAL_W-1:0]            depth_value;
  logic                                 quality_present;
  logic [gqc_pkg::VAL_W-1:0]            quality_value;
  logic [gqc_pkg::SLOT_W-1:0]           slot_count;
  logic signed [gqc_pkg::ALLELE_W-1:0]  allele_first;
  logic signed [gqc_pkg::ALLELE_W-1:0]  allele_second;
  logic [gqc_pkg::CLASS_W-1:0]          class_first;
  logic [gqc_pkg::CLASS_W-1:0]          class_second;
  logic [gqc_pkg::ALLELE_W-1:0]         allele_total;

  modport source (
    output valid, opcode, sample_index, depth_present, depth_value, quality_present,
           quality_value, slot_count, allele_first, allele_second, class_first,
           class_second, allele_total,
    input  ready
  );
  modport sink (
    input  valid, opcode, sample_index, depth_present, depth_value, quality_present,
           quality_value, slot_count, allele_first, allele_second, class_first,
           class_second, allele_total,
    output ready
  );
endinterface

interface gqc_out_if;
  logic                       valid;
  logic                       ready;
  logic [gqc_pkg::COL_W-1:0]  counter_id;
  logic [gqc_pkg::CNT_W-1:0]  counter_value;
  logic                       is_null;
  logic                       last;

  modport source (output valid, counter_id, counter_value, is_null, last, input ready);
  modport sink (input valid, counter_id, counter_value, is_null, last, output ready);
endinterface

`default_nettype wire

>>> hdl/gqc_ram.sv
// ----------------------------------------------------------------------------
// gqc_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gqc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/gqc_decode.sv
// ----------------------------------------------------------------------------
// gqc_decode
// Turns the genotype slots of one record into small counter increments.
// ----------------------------------------------------------------------------
`default_nettype none

module gqc_decode (
  input  wire logic [gqc_pkg::SLOT_W-1:0]          slot_count,
  input  wire logic signed [gqc_pkg::ALLELE_W-1:0] allele_first,
  input  wire logic signed [gqc_pkg::ALLELE_W-1:0] allele_second,
  input  wire logic [gqc_pkg::CLASS_W-1:0]         class_first,
  input  wire logic [gqc_pkg::CLASS_W-1:0]         class_second,
  input  wire logic [gqc_pkg::ALLELE_W-1:0]        allele_total,
  output gqc_pkg::geno_t                           geno
);

  logic [gqc_pkg::ALLELE_W-1:0] total_sat;
  logic [gqc_pkg::SLOT_W-1:0]   nslots;
  logic                         used0, used1;
  logic                         missing, is_ref, is_hom;
  logic                         vt0, vt1, single0, single1;

  always_comb begin
    total_sat = (allele_total > gqc_pkg::ALLELE_W'(gqc_pkg::MAX_ALLELES)) ?
                gqc_pkg::ALLELE_W'(gqc_pkg::MAX_ALLELES) : allele_total;
    nslots = (slot_count > gqc_pkg::SLOT_W'(gqc_pkg::PLOIDY)) ?
             gqc_pkg::SLOT_W'(gqc_pkg::PLOIDY) : slot_count;
    used0 = nslots >= 2'd1;
    used1 = nslots >= 2'd2;

    missing = (!used0 || allele_first < 7'sd0) && (!used1 || allele_second < 7'sd0);
    is_ref  = (!used0 || allele_first == 7'sd0) && (!used1 || allele_second == 7'sd0);
    is_hom  = !used1 || allele_second == allele_first;

    // A slot adds to the variant-type counts only for a real alternate allele.
    vt0 = used0 && allele_first > 7'sd0 && $unsigned(allele_first) < total_sat;
    vt1 = used1 && allele_second > 7'sd0 && $unsigned(allele_second) < total_sat;

    single0 = used0 && allele_first > 7'sd0 && !(used1 && allele_second == allele_first);
    single1 = used1 && allele_second > 7'sd0 && allele_second != allele_first;

    geno.called     = {1'b0, !missing};
    geno.not_called = {1'b0, missing};
    geno.hom_ref    = {1'b0, !missing && is_hom && is_ref};
    geno.het        = {1'b0, !missing && !is_hom};
    geno.singleton  = 2'(single0) + 2'(single1);
    geno.ti   = 2'(vt0 && class_first == gqc_pkg::CLS_TI) +
                2'(vt1 && class_second == gqc_pkg::CLS_TI);
    geno.tv   = 2'(vt0 && class_first == gqc_pkg::CLS_TV) +
                2'(vt1 && class_second == gqc_pkg::CLS_TV);
    geno.ins  = 2'(vt0 && class_first == gqc_pkg::CLS_INS) +
                2'(vt1 && class_second == gqc_pkg::CLS_INS);
    geno.del  = 2'(vt0 && class_first == gqc_pkg::CLS_DEL) +
                2'(vt1 && class_second == gqc_pkg::CLS_DEL);
    geno.star = 2'(vt0 && class_first == gqc_pkg::CLS_STAR) +
                2'(vt1 && class_second == gqc_pkg::CLS_STAR);
    geno.snp   = geno.ti + geno.tv;
    geno.multi = {1'b0, total_sat > gqc_pkg::ALLELE_W'(gqc_pkg::MULTI_THRESHOLD)};
  end

endmodule

`default_nettype wire

>>> hdl/gqc_alu.sv
// ----------------------------------------------------------------------------
// gqc_alu
// Shared 64-bit update unit: wrapping add, minimum or maximum of one counter.
// ----------------------------------------------------------------------------
`default_nettype none

module gqc_alu (
  input  wire gqc_pkg::alu_ctl_t               ctl,
  input  wire logic [gqc_pkg::CNT_W-1:0]       old_val,
  input  wire logic [gqc_pkg::CNT_W-1:0]       opnd,
  output logic      [gqc_pkg::CNT_W-1:0]       result
);

  always_comb begin
    if (!ctl.en) begin
      result = old_val;
    end else begin
      unique case (ctl.op)
        gqc_pkg::ALU_ADD: result = old_val + opnd;
        gqc_pkg::ALU_MIN: result = (opnd < old_val) ? opnd : old_val;
        gqc_pkg::ALU_MAX: result = (opnd > old_val) ? opnd : old_val;
        default:          result = old_val;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/genotype_qc_stats_accumulator.sv
// ----------------------------------------------------------------------------
// genotype_qc_stats_accumulator
// Per-sample genotype QC counters held in one memory, 23 words to a sample.
// ----------------------------------------------------------------------------
//   channel  direction  item
//   in_ch    sink       record to accumulate, or readout request for a sample
//   out_ch   source     one counter (id, value, null flag, last flag)
//
// After reset the memory is initialised one word a cycle, 23552 words, with
// in_ch.ready low. An accumulate holds it low through the two squares on
// the shared multiplier and the pipelined read-modify-write of the 23 words
// through the single memory, so the next record waits for the last write-back.
// A readout holds it low while it reads the DP and GQ counts, then for each
// counter while it is read and offered, longer while out_ch.ready is held low.
// ----------------------------------------------------------------------------
`default_nettype none

module genotype_qc_stats_accumulator (
  input wire logic   clk,
  input wire logic   rst_n,
  gqc_in_if.sink     in_ch,
  gqc_out_if.source  out_ch
);

  gqc_pkg::state_t state_r, state_nxt;

  logic [gqc_pkg::ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [gqc_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [gqc_pkg::COL_W-1:0]    wb_col_r, wb_col_nxt;
  logic                         wb_vld_r, wb_vld_nxt;
  logic [gqc_pkg::ADDR_W-1:0]   base_r, base_nxt;
  logic                         dp_pres_r, dp_pres_nxt;
  logic                         gq_pres_r, gq_pres_nxt;
  logic [gqc_pkg::VAL_W-1:0]    dp_val_r, dp_val_nxt;
  logic [gqc_pkg::VAL_W-1:0]    gq_val_r, gq_val_nxt;
  gqc_pkg::geno_t               geno_r, geno_nxt, geno_dec;
  logic [gqc_pkg::CNT_W-1:0]    sq_dp_r, sq_dp_nxt;
  logic [gqc_pkg::CNT_W-1:0]    sq_gq_r, sq_gq_nxt;
  logic                         dp_null_r, dp_null_nxt;
  logic                         gq_null_r, gq_null_nxt;
  logic [gqc_pkg::COL_W-1:0]    out_id_r, out_id_nxt;
  logic [gqc_pkg::CNT_W-1:0]    out_val_r, out_val_nxt;
  logic                         out_null_r, out_null_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         in_acc;
  logic                         sample_ok;
  logic                         col_null;
  logic [gqc_pkg::VAL_W-1:0]    mul_a;
  logic [2*gqc_pkg::VAL_W-1:0]  mul_p;
  logic                         ram_we;
  logic [gqc_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [gqc_pkg::CNT_W-1:0]    ram_wdata, ram_rdata;
  gqc_pkg::alu_ctl_t            alu_ctl;
  logic [gqc_pkg::CNT_W-1:0]    alu_opnd, alu_res;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign sample_ok = 32'(in_ch.sample_index) < gqc_pkg::NUM_SAMPLES;

  assign in_ch.ready          = (state_r == gqc_pkg::ST_IDLE);
  assign out_ch.valid         = (state_r == gqc_pkg::ST_RD_WAIT);
  assign out_ch.counter_id    = out_id_r;
  assign out_ch.counter_value = out_val_r;
  assign out_ch.is_null       = out_null_r;
  assign out_ch.last          = out_last_r;

  gqc_decode u_decode (
    .slot_count    (in_ch.slot_count),
    .allele_first  (in_ch.allele_first),
    .allele_second (in_ch.allele_second),
    .class_first   (in_ch.class_first),
    .class_second  (in_ch.class_second),
    .allele_total  (in_ch.allele_total),
    .geno          (geno_dec)
  );

  gqc_ram #(
    .WIDTH (gqc_pkg::CNT_W),
    .DEPTH (gqc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gqc_alu u_alu (
    .ctl     (alu_ctl),
    .old_val (ram_rdata),
    .opnd    (alu_opnd),
    .result  (alu_res)
  );

  // One multiplier serves both squares, in ST_SQ_DP and then in ST_SQ_GQ.
  assign mul_a = (state_r == gqc_pkg::ST_SQ_DP) ? dp_val_r : gq_val_r;
  assign mul_p = mul_a * mul_a;

  assign col_null = (col_r < gqc_pkg::C_GQ_SUM) ? dp_null_r :
                    (col_r < gqc_pkg::C_RECORDS) ? gq_null_r : 1'b0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gqc_pkg::ST_CLEAR: begin
        if (clr_addr_r == gqc_pkg::ADDR_W'(gqc_pkg::RAM_DEPTH - 1)) begin
          state_nxt = gqc_pkg::ST_IDLE;
        end
      end
      gqc_pkg::ST_IDLE: begin
        if (in_acc && sample_ok) begin
          state_nxt = (in_ch.opcode == gqc_pkg::OPC_READ) ? gqc_pkg::ST_RD_DP :
                                                            gqc_pkg::ST_SQ_DP;
        end
      end
      gqc_pkg::ST_SQ_DP:    state_nxt = gqc_pkg::ST_SQ_GQ;
      gqc_pkg::ST_SQ_GQ:    state_nxt = gqc_pkg::ST_ACC;
      gqc_pkg::ST_ACC: begin
        if (wb_vld_r && wb_col_r == gqc_pkg::C_MULTI) begin
          state_nxt = gqc_pkg::ST_IDLE;
        end
      end
      gqc_pkg::ST_RD_DP:    state_nxt = gqc_pkg::ST_RD_GQ;
      gqc_pkg::ST_RD_GQ:    state_nxt = gqc_pkg::ST_RD_ISSUE;
      gqc_pkg::ST_RD_ISSUE: state_nxt = gqc_pkg::ST_RD_DATA;
      gqc_pkg::ST_RD_DATA:  state_nxt = gqc_pkg::ST_RD_WAIT;
      gqc_pkg::ST_RD_WAIT: begin
        if (out_ch.ready) begin
          state_nxt = out_last_r ? gqc_pkg::ST_IDLE : gqc_pkg::ST_RD_DATA;
        end
      end
      default: state_nxt = gqc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    alu_ctl.op = gqc_pkg::ALU_ADD;
    alu_ctl.en = 1'b1;
    alu_opnd   = '0;
    unique case (wb_col_r)
      gqc_pkg::C_DP_SUM: begin
        alu_ctl.en = dp_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(dp_val_r);
      end
      gqc_pkg::C_DP_SUM2: begin
        alu_ctl.en = dp_pres_r;
        alu_opnd   = sq_dp_r;
      end
      gqc_pkg::C_DP_COUNT: begin
        alu_ctl.en = dp_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(1);
      end
      gqc_pkg::C_DP_MIN: begin
        alu_ctl.op = gqc_pkg::ALU_MIN;
        alu_ctl.en = dp_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(dp_val_r);
      end
      gqc_pkg::C_DP_MAX: begin
        alu_ctl.op = gqc_pkg::ALU_MAX;
        alu_ctl.en = dp_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(dp_val_r);
      end
      gqc_pkg::C_GQ_SUM: begin
        alu_ctl.en = gq_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(gq_val_r);
      end
      gqc_pkg::C_GQ_SUM2: begin
        alu_ctl.en = gq_pres_r;
        alu_opnd   = sq_gq_r;
      end
      gqc_pkg::C_GQ_COUNT: begin
        alu_ctl.en = gq_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(1);
      end
      gqc_pkg::C_GQ_MIN: begin
        alu_ctl.op = gqc_pkg::ALU_MIN;
        alu_ctl.en = gq_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(gq_val_r);
      end
      gqc_pkg::C_GQ_MAX: begin
        alu_ctl.op = gqc_pkg::ALU_MAX;
        alu_ctl.en = gq_pres_r;
        alu_opnd   = gqc_pkg::CNT_W'(gq_val_r);
      end
      gqc_pkg::C_RECORDS:    alu_opnd = gqc_pkg::CNT_W'(1);
      gqc_pkg::C_CALLED:     alu_opnd = gqc_pkg::CNT_W'(geno_r.called);
      gqc_pkg::C_NOT_CALLED: alu_opnd = gqc_pkg::CNT_W'(geno_r.not_called);
      gqc_pkg::C_HOM_REF:    alu_opnd = gqc_pkg::CNT_W'(geno_r.hom_ref);
      gqc_pkg::C_HET:        alu_opnd = gqc_pkg::CNT_W'(geno_r.het);
      gqc_pkg::C_SINGLETON:  alu_opnd = gqc_pkg::CNT_W'(geno_r.singleton);
      gqc_pkg::C_SNP:        alu_opnd = gqc_pkg::CNT_W'(geno_r.snp);
      gqc_pkg::C_INS:        alu_opnd = gqc_pkg::CNT_W'(geno_r.ins);
      gqc_pkg::C_DEL:        alu_opnd = gqc_pkg::CNT_W'(geno_r.del);
      gqc_pkg::C_TI:         alu_opnd = gqc_pkg::CNT_W'(geno_r.ti);
      gqc_pkg::C_TV:         alu_opnd = gqc_pkg::CNT_W'(geno_r.tv);
      gqc_pkg::C_STAR:       alu_opnd = gqc_pkg::CNT_W'(geno_r.star);
      gqc_pkg::C_MULTI:      alu_opnd = gqc_pkg::CNT_W'(geno_r.multi);
      default:               alu_ctl.en = 1'b0;
    endcase
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    col_nxt      = col_r;
    wb_col_nxt   = wb_col_r;
    wb_vld_nxt   = wb_vld_r;
    base_nxt     = base_r;
    dp_pres_nxt  = dp_pres_r;
    gq_pres_nxt  = gq_pres_r;
    dp_val_nxt   = dp_val_r;
    gq_val_nxt   = gq_val_r;
    geno_nxt     = geno_r;
    sq_dp_nxt    = sq_dp_r;
    sq_gq_nxt    = sq_gq_r;
    dp_null_nxt  = dp_null_r;
    gq_null_nxt  = gq_null_r;
    out_id_nxt   = out_id_r;
    out_val_nxt  = out_val_r;
    out_null_nxt = out_null_r;
    out_last_nxt = out_last_r;
    ram_we       = 1'b0;
    ram_waddr    = base_r + gqc_pkg::ADDR_W'(col_r);
    ram_wdata    = gqc_pkg::col_init(col_r);
    ram_raddr    = base_r + gqc_pkg::ADDR_W'(col_r);

    unique case (state_r)
      gqc_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        col_nxt      = (col_r == gqc_pkg::C_MULTI) ? '0 : col_r + 1'b1;
      end
      gqc_pkg::ST_IDLE: begin
        if (in_acc) begin
          base_nxt    = gqc_pkg::ADDR_W'(32'(in_ch.sample_index) * gqc_pkg::NCOL);
          dp_pres_nxt = in_ch.depth_present;
          gq_pres_nxt = in_ch.quality_present;
          dp_val_nxt  = in_ch.depth_value;
          gq_val_nxt  = in_ch.quality_value;
          geno_nxt    = geno_dec;
          col_nxt     = '0;
          wb_vld_nxt  = 1'b0;
        end
      end
      gqc_pkg::ST_SQ_DP: sq_dp_nxt = gqc_pkg::CNT_W'(mul_p);
      gqc_pkg::ST_SQ_GQ: sq_gq_nxt = gqc_pkg::CNT_W'(mul_p);
      gqc_pkg::ST_ACC: begin
        // Read one word ahead of the write-back of the previous one.
        ram_raddr  = base_r + gqc_pkg::ADDR_W'((col_r == gqc_pkg::C_END) ?
                                               gqc_pkg::C_MULTI : col_r);
        wb_vld_nxt = (col_r != gqc_pkg::C_END);
        wb_col_nxt = col_r;
        if (col_r != gqc_pkg::C_END) begin
          col_nxt = col_r + 1'b1;
        end
        ram_we    = wb_vld_r;
        ram_waddr = base_r + gqc_pkg::ADDR_W'(wb_col_r);
        ram_wdata = alu_res;
      end
      gqc_pkg::ST_RD_DP: begin
        ram_raddr = base_r + gqc_pkg::ADDR_W'(gqc_pkg::C_DP_COUNT);
      end
      gqc_pkg::ST_RD_GQ: begin
        ram_raddr   = base_r + gqc_pkg::ADDR_W'(gqc_pkg::C_GQ_COUNT);
        dp_null_nxt = (ram_rdata == '0);
      end
      gqc_pkg::ST_RD_ISSUE: begin
        gq_null_nxt = (ram_rdata == '0);
      end
      gqc_pkg::ST_RD_DATA: begin
        out_id_nxt   = col_r;
        out_null_nxt = col_null;
        out_val_nxt  = col_null ? '0 : ram_rdata;
        out_last_nxt = (col_r == gqc_pkg::C_MULTI);
        ram_we       = 1'b1;
      end
      gqc_pkg::ST_RD_WAIT: begin
        if (!out_last_r) begin
          ram_raddr = base_r + gqc_pkg::ADDR_W'(col_r + 1'b1);
          if (out_ch.ready) begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gqc_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      col_r      <= '0;
      wb_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      col_r      <= col_nxt;
      wb_vld_r   <= wb_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_col_r   <= wb_col_nxt;
    base_r     <= base_nxt;
    dp_pres_r  <= dp_pres_nxt;
    gq_pres_r  <= gq_pres_nxt;
    dp_val_r   <= dp_val_nxt;
    gq_val_r   <= gq_val_nxt;
    geno_r     <= geno_nxt;
    sq_dp_r    <= sq_dp_nxt;
    sq_gq_r    <= sq_gq_nxt;
    dp_null_r  <= dp_null_nxt;
    gq_null_r  <= gq_null_nxt;
    out_id_r   <= out_id_nxt;
    out_val_r  <= out_val_nxt;
    out_null_r <= out_null_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/gqc_checker.sv
// ----------------------------------------------------------------------------
// gqc_checker
// Port-level checks of the genotype QC statistics accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module gqc_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [gqc_pkg::COL_W-1:0] out_counter_id,
  input wire logic [gqc_pkg::CNT_W-1:0] out_counter_value,
  input wire logic                      out_is_null,
  input wire logic                      out_last
);

  // The block never offers a readout item while it is ready for a new record.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("output item offered while input is ready");

  // Once an item is taken the block works on it before taking another.
  a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after an accepted item");

  a_last_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_counter_id == gqc_pkg::C_MULTI)))
    else $error("last flag does not match the final counter");

  a_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_null) |->
      (out_counter_value == '0 && out_counter_id < gqc_pkg::C_RECORDS))
    else $error("null item with a value or outside the DP and GQ groups");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_counter_id)))
    else $error("stalled output item dropped or changed");

endmodule

bind genotype_qc_stats_accumulator gqc_checker u_gqc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_counter_id    (out_ch.counter_id),
  .out_counter_value (out_ch.counter_value),
  .out_is_null       (out_ch.is_null),
  .out_last          (out_ch.last)
);

`default_nettype wire

>>> dv/genotype_qc_stats_accumulator_test.sv
// ----------------------------------------------------------------------------
// genotype_qc_stats_accumulator_test
// Self-checking bench for the per-sample genotype QC counter accumulator.
// Records and readout requests are offered on the record channel from a
// queue. Each accepted item is folded into a local copy of every sample's
// counter row. A readout turns that row into 23 expected counter items, which
// are matched in order against what the block returns. Both channels idle
// and stall at random, and marked items wait for the counters to drain.
// ----------------------------------------------------------------------------
module genotype_qc_stats_accumulator_test;
  import gqc_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int TAIL_CYCLES    = 100;
  localparam int RANDOM_RECORDS = 140;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [VAL_W-1:0]   TOP_VAL    = '1;
  localparam logic [CLASS_W-1:0] CLS_SPARE6 = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_SPARE7 = 3'd7;

  typedef struct {
    logic                       opcode;
    logic [SAMPLE_W-1:0]        sample_index;
    logic                       depth_present;
    logic [VAL_W-1:0]           depth_value;
    logic                       quality_present;
    logic [VAL_W-1:0]           quality_value;
    logic [SLOT_W-1:0]          slot_count;
    logic signed [ALLELE_W-1:0] allele_first;
    logic signed [ALLELE_W-1:0] allele_second;
    logic [CLASS_W-1:0]         class_first;
    logic [CLASS_W-1:0]         class_second;
    logic [ALLELE_W-1:0]        allele_total;
    bit                         drain;
  } rec_t;

  typedef struct {
    logic [COL_W-1:0] id;
    logic [CNT_W-1:0] value;
    logic             is_null;
    logic             last;
  } counter_t;

  logic clk;
  logic rst_n;

  gqc_in_if  in_ch ();
  gqc_out_if out_ch ();

  genotype_qc_stats_accumulator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [CNT_W-1:0]    sample_counters [NUM_SAMPLES][NCOL];
  rec_t                pending_records [$];
  counter_t            expected_counters [$];
  rec_t                cur_rec;
  logic [SAMPLE_W-1:0] hot_samples [6] = '{10'd0, 10'd1, 10'd5, 10'd341, 10'd682, 10'd1023};

  int          fail_count;
  int          records_sent;
  int          counters_seen;
  int unsigned gap_left;
  int unsigned hold_left;
  int          quiet_cycles;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  function automatic void add_pending(input rec_t r);
    pending_records.insert(pending_records.size(), r);
  endfunction

  function automatic void add_expected(input counter_t c);
    expected_counters.insert(expected_counters.size(), c);
  endfunction

  function automatic int unsigned draw_gap(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void clear_sample(input int s);
    for (int j = 0; j < NCOL; j++) begin
      sample_counters[s][j] = (j == C_DP_MIN || j == C_GQ_MIN) ? '1 : '0;
    end
  endfunction

  // Folds one present DP or GQ value into the five words starting at base.
  function automatic void fold_metric(input int s, input int base, input logic [CNT_W-1:0] v);
    sample_counters[s][base]     += v;
    sample_counters[s][base + 1] += v * v;
    sample_counters[s][base + 2] += 1;
    if (v < sample_counters[s][base + 3]) sample_counters[s][base + 3] = v;
    if (v > sample_counters[s][base + 4]) sample_counters[s][base + 4] = v;
  endfunction

  function automatic void fold_record(input rec_t r);
    int                 s;
    int                 slots;
    int                 total;
    int                 hits;
    int                 allele [2];
    logic [CLASS_W-1:0] kind [2];
    bit                 all_ref;
    bit                 all_hom;
    bit                 all_missing;
    bit                 dup_before;
    bit                 dp_null;
    bit                 gq_null;
    int                 n_ti, n_tv, n_ins, n_del, n_star, n_single;
    counter_t           c;
    s = r.sample_index;
    if (r.opcode == OPC_READ) begin
      dp_null = sample_counters[s][C_DP_COUNT] == 0;
      gq_null = sample_counters[s][C_GQ_COUNT] == 0;
      for (int j = 0; j < NCOL; j++) begin
        c.id      = COL_W'(j);
        c.is_null = (j < C_GQ_SUM && dp_null) || (j >= C_GQ_SUM && j < C_RECORDS && gq_null);
        c.value   = c.is_null ? '0 : sample_counters[s][j];
        c.last    = (j == NCOL - 1);
        add_expected(c);
      end
      clear_sample(s);
      return;
    end

    if (r.depth_present) fold_metric(s, C_DP_SUM, CNT_W'(r.depth_value));
    if (r.quality_present) fold_metric(s, C_GQ_SUM, CNT_W'(r.quality_value));

    slots = (r.slot_count > PLOIDY) ? PLOIDY : r.slot_count;
    total = (r.allele_total > MAX_ALLELES) ? MAX_ALLELES : r.allele_total;
    allele[0] = r.allele_first;
    allele[1] = r.allele_second;
    kind[0] = r.class_first;
    kind[1] = r.class_second;
    all_ref = 1'b1;
    all_hom = 1'b1;
    all_missing = 1'b1;
    n_ti = 0;
    n_tv = 0;
    n_ins = 0;
    n_del = 0;
    n_star = 0;
    n_single = 0;

    for (int i = 0; i < slots; i++) begin
      all_ref = all_ref && allele[i] == 0;
      all_hom = all_hom && allele[i] == allele[0];
      all_missing = all_missing && allele[i] < 0;
      if (allele[i] > 0 && allele[i] < total) begin
        case (kind[i])
          CLS_TI:   n_ti++;
          CLS_TV:   n_tv++;
          CLS_INS:  n_ins++;
          CLS_DEL:  n_del++;
          CLS_STAR: n_star++;
          default: ;
        endcase
      end
    end

    for (int i = 0; i < slots; i++) begin
      if (allele[i] > 0) begin
        hits = 0;
        dup_before = 1'b0;
        for (int j = 0; j < slots; j++) begin
          if (allele[j] == allele[i]) begin
            hits++;
            if (j < i) dup_before = 1'b1;
          end
        end
        if (!dup_before && hits == 1) n_single++;
      end
    end

    sample_counters[s][C_RECORDS]    += 1;
    sample_counters[s][C_CALLED]     += all_missing ? 0 : 1;
    sample_counters[s][C_NOT_CALLED] += all_missing ? 1 : 0;
    sample_counters[s][C_HOM_REF]    += (!all_missing && all_hom && all_ref) ? 1 : 0;
    sample_counters[s][C_HET]        += (!all_missing && !all_hom) ? 1 : 0;
    sample_counters[s][C_SINGLETON]  += CNT_W'(n_single);
    sample_counters[s][C_SNP]        += CNT_W'(n_ti + n_tv);
    sample_counters[s][C_INS]        += CNT_W'(n_ins);
    sample_counters[s][C_DEL]        += CNT_W'(n_del);
    sample_counters[s][C_TI]         += CNT_W'(n_ti);
    sample_counters[s][C_TV]         += CNT_W'(n_tv);
    sample_counters[s][C_STAR]       += CNT_W'(n_star);
    sample_counters[s][C_MULTI]      += (total > MULTI_THRESHOLD) ? 1 : 0;
  endfunction

  function automatic rec_t make_rec(input logic opc, input int s, input logic dp_on,
                                    input logic [VAL_W-1:0] dp, input logic gq_on,
                                    input logic [VAL_W-1:0] gq, input int slots,
                                    input int a0, input int a1,
                                    input logic [CLASS_W-1:0] c0,
                                    input logic [CLASS_W-1:0] c1, input int total);
    rec_t r;
    r.opcode          = opc;
    r.sample_index    = SAMPLE_W'(s);
    r.depth_present   = dp_on;
    r.depth_value     = dp;
    r.quality_present = gq_on;
    r.quality_value   = gq;
    r.slot_count      = SLOT_W'(slots);
    r.allele_first    = ALLELE_W'(a0);
    r.allele_second   = ALLELE_W'(a1);
    r.class_first     = c0;
    r.class_second    = c1;
    r.allele_total    = ALLELE_W'(total);
    r.drain           = 1'b0;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return VAL_W'($urandom_range(0, 200));
    if (roll < 85) return VAL_W'($urandom);
    if (roll < 93) return TOP_VAL;
    return '0;
  endfunction

  function automatic int pick_allele(input int total);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return -1;
    if (roll < 45 || total < 2) return 0;
    return $urandom_range(1, total - 1);
  endfunction

  // Well-formed records keep alleles and classes in range; the rest is noise.
  function automatic rec_t random_record(input bit well_formed);
    rec_t r;
    int   total;
    r.opcode          = OPC_ACC;
    r.sample_index    = ($urandom_range(0, 99) < 75) ? hot_samples[$urandom_range(0, 5)]
                                                     : SAMPLE_W'($urandom);
    r.depth_present   = $urandom_range(0, 99) < 85;
    r.depth_value     = draw_value();
    r.quality_present = $urandom_range(0, 99) < 80;
    r.quality_value   = draw_value();
    r.drain           = 1'b0;
    if (well_formed) begin
      total = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 64);
      r.slot_count    = ($urandom_range(0, 9) == 0) ? SLOT_W'(1) : SLOT_W'(2);
      r.allele_first  = ALLELE_W'(pick_allele(total));
      r.allele_second = ALLELE_W'(pick_allele(total));
      r.class_first   = CLASS_W'($urandom_range(0, 5));
      r.class_second  = CLASS_W'($urandom_range(0, 5));
      r.allele_total  = ALLELE_W'(total);
    end else begin
      r.slot_count    = SLOT_W'($urandom_range(0, 3));
      r.allele_first  = ALLELE_W'($urandom);
      r.allele_second = ALLELE_W'($urandom);
      r.class_first   = CLASS_W'($urandom);
      r.class_second  = CLASS_W'($urandom);
      r.allele_total  = ALLELE_W'($urandom);
    end
    return r;
  endfunction

  function automatic rec_t read_of(input int s);
    rec_t r;
    r = random_record(1'b0);
    r.opcode = OPC_READ;
    r.sample_index = SAMPLE_W'(s);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : feed
    rec_t nxt;
    bit   took;
    if (rst_n) begin
      took = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        fold_record(cur_rec);
        records_sent++;
        gap_left = draw_gap((records_sent / 24) % 3 == 2);
        took = 1'b1;
      end
      if (!in_ch.valid || took) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_records.size() != 0 &&
                     !(pending_records[0].drain && expected_counters.size() != 0)) begin
          nxt = pending_records.pop_front();
          cur_rec = nxt;
          in_ch.valid           <= 1'b1;
          in_ch.opcode          <= nxt.opcode;
          in_ch.sample_index    <= nxt.sample_index;
          in_ch.depth_present   <= nxt.depth_present;
          in_ch.depth_value     <= nxt.depth_value;
          in_ch.quality_present <= nxt.quality_present;
          in_ch.quality_value   <= nxt.quality_value;
          in_ch.slot_count      <= nxt.slot_count;
          in_ch.allele_first    <= nxt.allele_first;
          in_ch.allele_second   <= nxt.allele_second;
          in_ch.class_first     <= nxt.class_first;
          in_ch.class_second    <= nxt.class_second;
          in_ch.allele_total    <= nxt.allele_total;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : collect
    counter_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        counters_seen++;
        if (expected_counters.size() == 0) begin
          note_failure($sformatf("unexpected counter item: id %0d value %h null %b last %b",
                                 out_ch.counter_id, out_ch.counter_value, out_ch.is_null,
                                 out_ch.last));
        end else begin
          want = expected_counters.pop_front();
          if (out_ch.counter_id !== want.id || out_ch.counter_value !== want.value ||
              out_ch.is_null !== want.is_null || out_ch.last !== want.last) begin
            note_failure($sformatf({"counter mismatch: expected id %0d value %h null %b ",
                                    "last %b, got id %0d value %h null %b last %b"},
                                   want.id, want.value, want.is_null, want.last,
                                   out_ch.counter_id, out_ch.counter_value, out_ch.is_null,
                                   out_ch.last));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        hold_left = draw_gap((counters_seen / 64) % 3 == 1);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** genotype_qc_stats_accumulator: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    rec_t r;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.opcode          = OPC_ACC;
    in_ch.sample_index    = '0;
    in_ch.depth_present   = 1'b0;
    in_ch.depth_value     = '0;
    in_ch.quality_present = 1'b0;
    in_ch.quality_value   = '0;
    in_ch.slot_count      = '0;
    in_ch.allele_first    = '0;
    in_ch.allele_second   = '0;
    in_ch.class_first     = '0;
    in_ch.class_second    = '0;
    in_ch.allele_total    = '0;
    out_ch.ready          = 1'b0;
    fail_count            = 0;
    records_sent          = 0;
    counters_seen         = 0;
    gap_left              = 0;
    hold_left             = 0;
    quiet_cycles          = 0;
    for (int s = 0; s < NUM_SAMPLES; s++) clear_sample(s);

    add_pending(read_of(0));
    add_pending(make_rec(OPC_ACC, 5, 1, TOP_VAL, 1, 0, 2, 0, 0,
                         CLS_OTHER, CLS_OTHER, 1));
    add_pending(make_rec(OPC_ACC, 5, 1, TOP_VAL, 0, 0, 2, 1, 2,
                         CLS_TI, CLS_TV, 3));
    add_pending(make_rec(OPC_ACC, 5, 1, TOP_VAL, 0, 0, 2, 1, 1,
                         CLS_INS, CLS_INS, 2));
    add_pending(make_rec(OPC_ACC, 5, 1, TOP_VAL, 0, 0, 2, 63, -1,
                         CLS_DEL, CLS_OTHER, 64));
    add_pending(make_rec(OPC_ACC, 5, 1, TOP_VAL, 0, 0, 2, -1, -1,
                         CLS_TI, CLS_TV, 2));
    add_pending(make_rec(OPC_ACC, 5, 0, TOP_VAL, 1, TOP_VAL, 3, 2, 5,
                         CLS_STAR, CLS_SPARE7, 127));
    add_pending(make_rec(OPC_ACC, 5, 0, 0, 1, 1, 2, 5, 0,
                         CLS_TI, CLS_TI, 3));
    add_pending(make_rec(OPC_ACC, 5, 1, 0, 0, 0, 0, 1, 1,
                         CLS_TI, CLS_TI, 2));
    add_pending(make_rec(OPC_ACC, 5, 0, 0, 0, 0, 2, -64, 3,
                         CLS_SPARE6, CLS_DEL, 0));
    add_pending(make_rec(OPC_ACC, 5, 0, 0, 0, 0, 1, 1, 63,
                         CLS_STAR, CLS_SPARE7, 2));
    add_pending(read_of(5));
    add_pending(read_of(5));
    add_pending(make_rec(OPC_ACC, 1023, 0, TOP_VAL, 1, 12345, 2, 0, 1,
                         CLS_OTHER, CLS_TI, 2));
    add_pending(read_of(1023));
    add_pending(make_rec(OPC_ACC, 1023, 1, 777, 0, TOP_VAL, 2, 3, 3,
                         CLS_TV, CLS_TV, 65));
    add_pending(read_of(1023));

    for (int n = 0; n < RANDOM_RECORDS; n++) begin
      r = random_record($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 99) < 16) r.opcode = OPC_READ;
      r.drain = (n == RANDOM_RECORDS / 2) || ($urandom_range(0, 99) < 3);
      add_pending(r);
    end
    foreach (hot_samples[k]) begin
      r = read_of(hot_samples[k]);
      r.drain = (k == 0);
      add_pending(r);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_records.size() != 0 || in_ch.valid || expected_counters.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_counters.size() != 0) begin
      note_failure($sformatf("%0d counter items never arrived", expected_counters.size()));
    end
    if (fail_count == 0) begin
      $display("** genotype_qc_stats_accumulator: PASSED **");
    end else begin
      $display("** genotype_qc_stats_accumulator: FAILED **");
    end
    $finish;
  end

endmodule

>>> genotype_qc_stats_accumulator.f
hdl/gqc_pkg.sv
hdl/gqc_if.sv
hdl/gqc_ram.sv
hdl/gqc_decode.sv
hdl/gqc_alu.sv
hdl/genotype_qc_stats_accumulator.sv
hdl/gqc_checker.sv
dv/genotype_qc_stats_accumulator_test.sv
